>>> hdl/first_fit_extent_allocator_assert.svh
// Assertion macros used by the checker file of the extent allocator.
`ifndef FIRST_FIT_EXTENT_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_EXTENT_ALLOCATOR_ASSERT_SVH
// Implication that must hold at every clock edge outside reset.
`define FFEA_ASSERT_IMP(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// Implication whose consequent is checked in the next cycle.
`define FFEA_ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

>>> hdl/ffea_pkg.sv
// Package with the action and status codes and the sequencer states of the extent allocator.
package ffea_pkg;
  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_READ  = 2'd2,
    ACT_WRITE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_ALLOC_FAIL = 2'd1,
    ST_BAD_ADDR   = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_DROP_RD,
    S_DROP_WR,
    S_PUSH_RD,
    S_PUSH_WR,
    S_ZERO,
    S_CELL_RD,
    S_OUT
  } state_t;
endpackage

>>> hdl/first_fit_extent_allocator.sv
// Top level of the first-fit extent allocator: cell store, extent list and sequencer.
// The block holds a store of CELLS 32-bit cells and an ordered list of free extents
// [start, end). One input transfer carries an action: allocate, free an extent,
// read a cell or write a cell. Each accepted item gives exactly one result transfer
// carrying status, the granted extent and the read value.
// The block works on one item at a time: in_ready is high only while the sequencer
// is idle and no result is waiting. A rejected allocate is answered from idle; a
// read or write goes through the cell store; a free reads the last list entry and,
// if taken, moves each entry up and writes the new extent to entry zero; an allocate
// scans the list for the first large enough extent, trims it or on an exact fit
// moves the later entries down over it, then zeroes the granted cells. The worst
// case is set by the memory ports: the shift moves one entry and the zeroing pass
// clears one cell per cycle, and the scan reads and checks each entry in turn. The
// next item can be accepted in the cycle after the result transfer.
// The result waits in an output register until out_ready is high; a stalled
// receiver holds the block idle, and nothing is lost.
// Reset writes entry zero of the list with one extent covering the whole store and
// sets the free count to CELLS. The other list entries need no clearing pass: the
// extent count marks which entries are live. The cell store is not cleared.
module first_fit_extent_allocator #(
  parameter int CELLS       = 256,
  parameter int MAX_EXTENTS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [8:0]  amount,
  input  logic [7:0]  block_start,
  input  logic [8:0]  block_end,
  input  logic [8:0]  address,
  input  logic signed [31:0] write_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [7:0]  granted_start,
  output logic [8:0]  granted_end,
  output logic signed [31:0] read_value
);
  import ffea_pkg::*;

  localparam int CW = (CELLS > 2) ? $clog2(CELLS) : 1;          // cell index
  localparam int VW = $clog2(CELLS + 1);                        // cell count
  localparam int EW = (MAX_EXTENTS > 2) ? $clog2(MAX_EXTENTS) : 1;
  localparam int NW = $clog2(MAX_EXTENTS + 1);
  localparam logic [VW-1:0] CELLS_V = VW'(CELLS);
  localparam logic [NW-1:0] MAXE_V  = NW'(MAX_EXTENTS);

  // Memories: extent list (start and end in one word) and the cell store.
  logic [2*VW-1:0] ext_mem [MAX_EXTENTS];
  logic [31:0]     cell_mem [CELLS];

  state_t state, state_next;

  logic [NW-1:0] extent_count;
  logic [VW-1:0] free_cells;
  logic [NW-1:0] idx;          // list position in progress
  logic [VW-1:0] zc;           // next cell to zero
  logic [2*VW-1:0] ext_q;      // registered list read data
  logic [31:0]   cell_q;

  // Captured item.
  logic [1:0]    act;
  logic [VW-1:0] amt, bs, be;
  logic [8:0]    addr;
  logic [31:0]   wval;

  // List memory port controls.
  logic          ext_we;
  logic [EW-1:0] ext_wa, ext_ra;
  logic [2*VW-1:0] ext_wd;

  logic          cell_we;
  logic [CW-1:0] cell_a;
  logic [31:0]   cell_wd;

  // Compare/subtract unit on the registered list entry, used by the scan.
  logic [VW-1:0] ex_s, ex_e, size;
  assign ex_s = ext_q[2*VW-1:VW];
  assign ex_e = ext_q[VW-1:0];
  assign size = (ex_e > ex_s) ? ex_e - ex_s : '0;

  // Incoming field widening.
  logic [VW:0]   amt_w, bs_w, be_w;
  assign amt_w = (VW+1)'(amount);
  assign bs_w  = (VW+1)'(block_start);
  assign be_w  = (VW+1)'(block_end);

  logic accept;
  assign in_ready = (state == S_IDLE) && !out_valid;
  assign accept   = in_valid && in_ready;

  // An allocate of zero cells or of more than are free fails at once.
  logic alloc_reject;
  assign alloc_reject = (amount == 9'd0) || (amt_w > (VW+1)'(free_cells));

  logic addr_ok;
  assign addr_ok = ({23'd0, addr} < 32'(CELLS));

  logic free_ok;
  assign free_ok = (bs < CELLS_V) && (be > bs) && (extent_count < MAXE_V);

  // Loop end conditions for the scan, the list shift and the zeroing pass.
  logic last_entry, last_move, zero_last;
  assign last_entry = (idx + 1'b1 >= extent_count);
  assign last_move  = (idx + 2'd2 >= extent_count);
  assign zero_last  = (zc + 1'b1 >= VW'(granted_end)) || (zc + 1'b1 >= CELLS_V);

  always_ff @(posedge clk) begin
    if (ext_we) ext_mem[ext_wa] <= ext_wd;
    ext_q <= ext_mem[ext_ra];
    if (cell_we) cell_mem[cell_a] <= cell_wd;
    cell_q <= cell_mem[cell_a];
  end

  always_comb begin
    state_next = state;
    ext_we  = 1'b0;
    ext_wa  = idx[EW-1:0];
    ext_ra  = idx[EW-1:0];
    ext_wd  = ext_q;
    cell_we = 1'b0;
    cell_a  = addr[CW-1:0];
    cell_wd = wval;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (action_t'(action))
            ACT_ALLOC: state_next = alloc_reject ? S_IDLE : S_SCAN_RD;
            ACT_FREE:  state_next = S_PUSH_RD;
            default:   state_next = S_CELL_RD;
          endcase
        end
      end
      S_SCAN_RD: state_next = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (amt <= size) begin
          if (amt < size) begin
            ext_we = 1'b1;
            ext_wd = {ex_s + amt, ex_e};
            state_next = S_ZERO;
          end else begin
            ext_ra = EW'(idx + 1'b1);
            state_next = S_DROP_RD;
          end
        end else begin
          ext_ra = EW'(idx + 1'b1);
          state_next = last_entry ? S_IDLE : S_SCAN_RD;
        end
      end
      S_DROP_RD: begin
        ext_ra = EW'(idx + 1'b1);
        state_next = last_entry ? S_ZERO : S_DROP_WR;
      end
      S_DROP_WR: begin
        ext_we = 1'b1;
        ext_ra = EW'(idx + 2'd2);
        state_next = last_move ? S_ZERO : S_DROP_WR;
      end
      S_PUSH_RD: begin
        ext_ra = EW'(extent_count - 1'b1);
        state_next = free_ok ? S_PUSH_WR : S_IDLE;
      end
      S_PUSH_WR: begin
        ext_we = 1'b1;
        ext_ra = EW'(idx - 2'd2);
        if (idx == '0) begin
          ext_wd = {bs, be};
          state_next = S_IDLE;
        end
      end
      S_ZERO: begin
        cell_we = 1'b1;
        cell_a  = zc[CW-1:0];
        cell_wd = '0;
        if (zero_last) state_next = S_IDLE;
      end
      S_CELL_RD: begin
        cell_we = (act == ACT_WRITE) && addr_ok;
        state_next = S_OUT;
      end
      S_OUT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
    // During reset entry zero takes the extent that covers the whole store.
    if (rst) begin
      ext_we = 1'b1;
      ext_wa = '0;
      ext_wd = {{VW{1'b0}}, CELLS_V};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      extent_count <= NW'(1);
      free_cells   <= CELLS_V;
      out_valid    <= 1'b0;
      idx          <= '0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            act  <= action;
            amt  <= amt_w[VW] ? '1 : amt_w[VW-1:0];
            bs   <= bs_w[VW] ? '1 : bs_w[VW-1:0];
            be   <= (be_w > (VW+1)'(CELLS)) ? CELLS_V : be_w[VW-1:0];
            addr <= address;
            wval <= write_value;
            granted_start <= '0;
            granted_end   <= '0;
            read_value    <= '0;
            idx  <= '0;
            if (action_t'(action) == ACT_ALLOC && alloc_reject) begin
              status    <= ST_ALLOC_FAIL;
              out_valid <= 1'b1;
            end else begin
              status    <= ST_OK;
            end
          end
        end
        S_SCAN_CHK: begin
          if (amt <= size) begin
            granted_start <= 8'(ex_s);
            granted_end   <= 9'(ex_s + amt);
            zc            <= ex_s;
            free_cells    <= free_cells - amt;
          end else if (last_entry) begin
            status    <= ST_ALLOC_FAIL;
            out_valid <= 1'b1;
          end else begin
            idx   <= idx + 1'b1;
          end
        end
        S_DROP_RD: begin
          if (last_entry) extent_count <= extent_count - 1'b1;
        end
        S_DROP_WR: begin
          // ext_q holds entry idx+1; it moves down to idx.
          idx <= idx + 1'b1;
          if (last_move) extent_count <= extent_count - 1'b1;
        end
        S_PUSH_RD: begin
          if (!free_ok) out_valid <= 1'b1;
          else idx <= extent_count;
        end
        S_PUSH_WR: begin
          // Entry idx takes entry idx-1; at idx zero the new extent goes in.
          if (idx == '0) begin
            extent_count <= extent_count + 1'b1;
            free_cells   <= ((VW+1)'(free_cells) + (VW+1)'(be - bs) > (VW+1)'(CELLS))
                            ? CELLS_V : VW'(free_cells + (be - bs));
            out_valid <= 1'b1;
          end else begin
            idx <= idx - 1'b1;
          end
        end
        S_ZERO: begin
          zc <= zc + 1'b1;
          if (zero_last) out_valid <= 1'b1;
        end
        S_OUT: begin
          if (!addr_ok) status <= ST_BAD_ADDR;
          else if (act == ACT_READ) read_value <= cell_q;
          out_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule

>>> hdl/ffea_checker.sv
// Port-level checker for the extent allocator and its bind statement.
`include "first_fit_extent_allocator_assert.svh"
module ffea_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] status,
  input logic [7:0] granted_start,
  input logic [8:0] granted_end
);
  import ffea_pkg::*;
  `FFEA_ASSERT_IMP(a_no_accept_with_result, clk, rst, out_valid, !in_ready, "input taken while result pending")
  `FFEA_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready, "ready right after accept")
  `FFEA_ASSERT_NEXT(a_result_holds, clk, rst, out_valid && !out_ready, out_valid && $stable(status), "stalled result changed")
  `FFEA_ASSERT_IMP(a_status_code, clk, rst, out_valid, status != 2'd3, "undefined status code")
  `FFEA_ASSERT_IMP(a_grant_only_ok, clk, rst, out_valid && status != ST_OK, granted_end == 9'd0 && granted_start == 8'd0, "grant on failure")
endmodule

bind first_fit_extent_allocator ffea_checker u_ffea_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .status(status),
  .granted_start(granted_start), .granted_end(granted_end)
);
